### hdl/triangle_element_stiffness_top_assert.svh
// Assertion macros for the triangle element stiffness block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef TRIANGLE_ELEMENT_STIFFNESS_TOP_ASSERT_SVH
`define TRIANGLE_ELEMENT_STIFFNESS_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tes_pkg.sv
// Shared types, constants and helper functions of the triangle element stiffness block.
// No dependencies.
package tes_pkg;

  localparam int NODE_BITS = 16;

  localparam int IN_W     = 240;
  localparam int OUT_W    = 360;
  localparam int DIFF_W   = 33;
  localparam int PROD_W   = 64;
  localparam int TW_W     = 66;
  localparam int DEN_W    = 67;
  localparam int ENTRY_W  = 48;
  localparam int EF_W     = 62;
  localparam int ACC_W    = 129;
  localparam int QUO_W    = 50;
  localparam int REM_W    = 117;
  localparam int DSH_W    = 116;
  localparam int GROW_W   = 17;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_YOUNG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POISSON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;

  localparam logic [31:0] YOUNG_RST   = 32'd1;
  localparam logic [14:0] POISSON_RST = 15'd19661;
  localparam logic        MODE_RST    = 1'b0;

  // Lane sequence, one row of six entries.
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] CNT_MUL1     = 6'd0;
  localparam logic [CNT_W-1:0] CNT_MUL2     = 6'd1;
  localparam logic [CNT_W-1:0] CNT_ACC0     = 6'd2;
  localparam logic [CNT_W-1:0] CNT_ACC_LAST = 6'd9;
  localparam logic [CNT_W-1:0] CNT_SIGN     = 6'd10;
  localparam logic [CNT_W-1:0] CNT_DIV0     = 6'd11;
  localparam logic [CNT_W-1:0] CNT_DONE     = 6'd61;

  localparam logic [2:0] ROW_LAST = 3'd5;

  localparam logic [50:0] SAT_POS_LIM = 51'h7FFF_FFFF_FFFF;
  localparam logic [50:0] SAT_NEG_LIM = 51'h8000_0000_0000;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [ENTRY_W-1:0] ENTRY_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0]    b;
    logic [2:0][DIFF_W-1:0]    c;
    logic [TW_W-1:0]           tmag;
    logic                      tneg;
    logic [ENTRY_W-1:0]        area;
    logic                      degen;
    logic [2:0][NODE_BITS-1:0] node;
  } elem_t;

  typedef struct packed {
    logic       mul1;
    logic       mul2;
    logic       acc_en;
    logic       acc_first;
    logic       acc_term;
    logic [1:0] acc_part;
    logic       sgn;
    logic       div;
  } lane_ctl_t;

  typedef struct packed {
    logic [2:0]              local_row;
    logic [GROW_W-1:0]       global_row;
    logic [5:0][ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0]      area;
    logic                    degen;
    logic                    last;
  } result_t;

  // |v| modulo 2^32 of a 33-bit signed value.
  function automatic logic [31:0] abs32(input logic [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] n;
    n = ~v + 33'd1;
    return v[DIFF_W-1] ? n[31:0] : v[31:0];
  endfunction

  // Apply sign and clamp to the 48-bit signed range.
  function automatic logic [ENTRY_W-1:0] sat48(input logic [50:0] mag, input logic neg,
                                               input logic big);
    logic [50:0] n;
    n = ~mag + 51'd1;
    if (neg) begin
      return (big || mag > SAT_NEG_LIM) ? ENTRY_MIN : n[ENTRY_W-1:0];
    end
    return (big || mag > SAT_POS_LIM) ? ENTRY_MAX : mag[ENTRY_W-1:0];
  endfunction

endpackage

### hdl/tes_mat.sv
// Configuration registers and material factor unit (E*f00, E*f01, E*f22).
// Depends on tes_pkg; uses a 49-step restoring divider.
module tes_mat import tes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  ready,
  output logic [EF_W-1:0]       ef00,
  output logic [EF_W-1:0]       ef01,
  output logic [EF_W-1:0]       ef22
);

  typedef enum logic [4:0] {
    M_DEN  = 5'b00001,
    M_NUM  = 5'b00010,
    M_DIV  = 5'b00100,
    M_MUL  = 5'b01000,
    M_IDLE = 5'b10000
  } mat_state_t;

  localparam logic [1:0] F_00 = 2'd0;
  localparam logic [1:0] F_01 = 2'd1;
  localparam logic [1:0] F_22 = 2'd2;
  localparam logic [5:0] DIV_LAST = 6'd48;

  mat_state_t  state_r, state_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] young_r, young_nxt;
  logic [14:0] mu_r, mu_nxt;
  logic        mode_r, mode_nxt;
  logic [33:0] den_r;
  logic [48:0] n_r;
  logic [33:0] rem_r;
  logic [EF_W-1:0] ef00_r, ef01_r, ef22_r;

  logic [16:0] mplus, mminus, mminus2;
  logic [29:0] mu_sq;
  logic [33:0] den_w;
  logic [48:0] num_w;
  logic [34:0] trial;
  logic        ge;
  logic [EF_W-1:0] prod;

  assign mplus   = 17'd65536 + {2'b0, mu_r};
  assign mminus  = 17'd65536 - {2'b0, mu_r};
  assign mminus2 = 17'd65536 - {1'b0, mu_r, 1'b0};
  assign mu_sq   = mu_r * mu_r;
  assign trial   = {rem_r, n_r[48]};
  assign ge      = trial >= {1'b0, den_r};
  assign prod    = young_r * n_r[29:0];

  always_comb begin
    case (k_r)
      F_22:    den_w = {16'b0, mplus, 1'b0};
      default: den_w = mode_r ? (mplus * mminus2)
                              : (34'h1_0000_0000 - {4'b0, mu_sq});
    endcase
    case (k_r)
      F_00:    num_w = mode_r ? {mminus, 32'b0} : 49'h1_0000_0000_0000;
      F_01:    num_w = {2'b0, mu_r, 32'b0};
      default: num_w = 49'h0_0001_0000_0000;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    young_nxt = young_r;
    mu_nxt    = mu_r;
    mode_nxt  = mode_r;
    unique case (state_r)
      M_DEN:  state_nxt = M_NUM;
      M_NUM: begin
        state_nxt = M_DIV;
        cnt_nxt   = '0;
      end
      M_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) state_nxt = M_MUL;
      end
      M_MUL: begin
        if (k_r == F_22) begin
          state_nxt = M_IDLE;
        end else begin
          state_nxt = M_DEN;
          k_nxt     = k_r + 2'd1;
        end
      end
      M_IDLE: ;
      default: state_nxt = M_DEN;
    endcase
    if (cfg_we) begin
      state_nxt = M_DEN;
      k_nxt     = F_00;
      case (cfg_index)
        CFG_YOUNG:   young_nxt = cfg_wdata;
        CFG_POISSON: mu_nxt    = cfg_wdata[14:0];
        CFG_MODE:    mode_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_DEN;
      k_r     <= F_00;
      cnt_r   <= '0;
      young_r <= YOUNG_RST;
      mu_r    <= POISSON_RST;
      mode_r  <= MODE_RST;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      young_r <= young_nxt;
      mu_r    <= mu_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == M_DEN) den_r <= den_w;
    if (state_r == M_NUM) begin
      n_r   <= num_w + {15'b0, den_r[33:1]};
      rem_r <= '0;
    end
    if (state_r == M_DIV) begin
      rem_r <= ge ? 34'(trial - {1'b0, den_r}) : trial[33:0];
      n_r   <= {n_r[47:0], ge};
    end
    if (state_r == M_MUL) begin
      case (k_r)
        F_00:    ef00_r <= prod;
        F_01:    ef01_r <= prod;
        default: ef22_r <= prod;
      endcase
    end
  end

  assign ready = (state_r == M_IDLE);
  assign ef00  = ef00_r;
  assign ef01  = ef01_r;
  assign ef22  = ef22_r;

endmodule

### hdl/tes_front.sv
// Front pipeline: edge terms, doubled signed area, area output and degenerate flag.
// Depends on tes_pkg; pushes one elem_t per item into the queue.
module tes_front import tes_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic [IN_W-1:0] in_tdata,
  output logic            in_tready,
  input  logic            mat_ready,
  input  logic            q_full,
  output logic            q_push,
  output elem_t           q_data
);

  logic v1_r, v2_r, v3_r, en;
  logic [DIFF_W-1:0] dx21_r, dy31_r, dx31_r, dy21_r;
  logic [2:0][DIFF_W-1:0] b1_r, c1_r, b2_r, c2_r, b3_r, c3_r;
  logic [2:0][NODE_BITS-1:0] n1_r, n2_r, n3_r;
  logic [PROD_W-1:0] p1_r, p2_r;
  logic s1_r, s2_r;
  logic [TW_W-1:0] tw_r;

  logic [DIFF_W-1:0] x1, y1, x2, y2, x3, y3;
  logic [TW_W-1:0] e1, e2, tmag;
  logic [49:0] amag;

  assign x1 = {in_tdata[31], in_tdata[31:0]};
  assign y1 = {in_tdata[63], in_tdata[63:32]};
  assign x2 = {in_tdata[95], in_tdata[95:64]};
  assign y2 = {in_tdata[127], in_tdata[127:96]};
  assign x3 = {in_tdata[159], in_tdata[159:128]};
  assign y3 = {in_tdata[191], in_tdata[191:160]};

  assign en        = !v3_r || !q_full;
  assign in_tready = en && mat_ready;
  assign q_push    = v3_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid && in_tready;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Twice the signed area from two sign-magnitude products.
  assign e1 = s1_r ? 66'(~{2'b0, p1_r} + 66'd1) : {2'b0, p1_r};
  assign e2 = s2_r ? {2'b0, p2_r} : 66'(~{2'b0, p2_r} + 66'd1);

  always_ff @(posedge clk) begin
    if (en) begin
      dx21_r <= x2 - x1;
      dy31_r <= y3 - y1;
      dx31_r <= x3 - x1;
      dy21_r <= y2 - y1;
      b1_r   <= {y1 - y2, y3 - y1, y2 - y3};
      c1_r   <= {x2 - x1, x1 - x3, x3 - x2};
      n1_r   <= {NODE_BITS'(in_tdata[239:224]), NODE_BITS'(in_tdata[223:208]),
                 NODE_BITS'(in_tdata[207:192])};
      p1_r   <= abs32(dx21_r) * abs32(dy31_r);
      p2_r   <= abs32(dx31_r) * abs32(dy21_r);
      s1_r   <= dx21_r[DIFF_W-1] ^ dy31_r[DIFF_W-1];
      s2_r   <= dx31_r[DIFF_W-1] ^ dy21_r[DIFF_W-1];
      b2_r   <= b1_r;
      c2_r   <= c1_r;
      n2_r   <= n1_r;
      tw_r   <= e1 + e2;
      b3_r   <= b2_r;
      c3_r   <= c2_r;
      n3_r   <= n2_r;
    end
  end

  assign tmag = tw_r[TW_W-1] ? 66'(~tw_r + 66'd1) : tw_r;
  assign amag = {1'b0, tmag[65:17]} + {49'b0, tmag[16]};

  always_comb begin
    q_data.b     = b3_r;
    q_data.c     = c3_r;
    q_data.node  = n3_r;
    q_data.tmag  = tmag;
    q_data.tneg  = tw_r[TW_W-1];
    q_data.degen = (tw_r == '0);
    q_data.area  = q_data.degen ? '0 : sat48({1'b0, amag}, tw_r[TW_W-1], 1'b0);
  end

endmodule

### hdl/tes_fifo.sv
// Two-entry queue of classified elements between front and back.
// Depends on tes_pkg (elem_t).
module tes_fifo import tes_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  elem_t wr_data,
  input  logic  pop,
  output logic  full,
  output logic  valid,
  output elem_t head
);

  elem_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rp_r];

endmodule

### hdl/tes_lane.sv
// One stiffness column lane: two-term product accumulate, then 50-step divide by 2|T|.
// Depends on tes_pkg; sequenced by tes_back through lane_ctl_t.
module tes_lane import tes_pkg::*; (
  input  logic               clk,
  input  lane_ctl_t          ctl,
  input  logic [DIFF_W-1:0]  ra,
  input  logic [DIFF_W-1:0]  ca,
  input  logic [DIFF_W-1:0]  rb,
  input  logic [DIFF_W-1:0]  cb,
  input  logic [EF_W-1:0]    efa,
  input  logic [EF_W-1:0]    efb,
  input  logic [DEN_W-1:0]   dden,
  input  logic               tneg,
  output logic [ENTRY_W-1:0] entry
);

  logic [PROD_W-1:0] p1_r, p2_r;
  logic sa_r, sb_r;
  logic [ACC_W-1:0] acc_r;
  logic [REM_W-1:0] rem_r;
  logic [DSH_W-1:0] dsh_r;
  logic [QUO_W-1:0] q_r;
  logic big_r, neg_r;

  logic [EF_W-1:0]   ef_sel;
  logic [31:0]       ef_half, p_half;
  logic [PROD_W-1:0] p_sel, pp;
  logic [ACC_W-1:0]  ext, base, acc_nxt, amag;
  logic              ge, rnd;
  logic [50:0]       qr;

  assign ef_sel  = ctl.acc_term ? efb : efa;
  assign ef_half = ctl.acc_part[1] ? {2'b0, ef_sel[61:32]} : ef_sel[31:0];
  assign p_sel   = ctl.acc_term ? p2_r : p1_r;
  assign p_half  = ctl.acc_part[0] ? p_sel[63:32] : p_sel[31:0];
  assign pp      = ef_half * p_half;

  always_comb begin
    case (ctl.acc_part)
      2'b00:   ext = {65'b0, pp};
      2'b11:   ext = {1'b0, pp, 64'b0};
      default: ext = {33'b0, pp, 32'b0};
    endcase
    base    = ctl.acc_first ? '0 : acc_r;
    acc_nxt = (ctl.acc_term ? sb_r : sa_r) ? base - ext : base + ext;
  end

  assign amag = acc_r[ACC_W-1] ? ~acc_r + 129'd1 : acc_r;
  assign ge   = rem_r >= {1'b0, dsh_r};
  assign rnd  = {rem_r, 1'b0} >= {51'b0, dden};
  assign qr   = {1'b0, q_r} + {50'b0, rnd};

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      p1_r <= abs32(ra) * abs32(ca);
      sa_r <= ra[DIFF_W-1] ^ ca[DIFF_W-1];
    end
    if (ctl.mul2) begin
      p2_r <= abs32(rb) * abs32(cb);
      sb_r <= rb[DIFF_W-1] ^ cb[DIFF_W-1];
    end
    if (ctl.acc_en) acc_r <= acc_nxt;
    if (ctl.sgn) begin
      big_r <= amag[127:0] >= {11'b0, dden, 50'b0};
      rem_r <= amag[REM_W-1:0];
      dsh_r <= {dden, 49'b0};
      q_r   <= '0;
      neg_r <= acc_r[ACC_W-1] ^ tneg;
    end
    if (ctl.div) begin
      rem_r <= ge ? rem_r - {1'b0, dsh_r} : rem_r;
      q_r   <= {q_r[QUO_W-2:0], ge};
      dsh_r <= {1'b0, dsh_r[DSH_W-1:1]};
    end
  end

  assign entry = sat48(qr, neg_r, big_r);

endmodule

### hdl/tes_back.sv
// Back end: row sequencer, six column lanes and the result output register.
// Depends on tes_pkg and tes_lane.
module tes_back import tes_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  elem_t           head,
  input  logic            head_valid,
  output logic            pop,
  input  logic [EF_W-1:0] ef00,
  input  logic [EF_W-1:0] ef01,
  input  logic [EF_W-1:0] ef22,
  input  logic            out_ready,
  output logic            out_valid,
  output result_t         res
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       row_r, row_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r;

  lane_ctl_t        ctl;
  logic [CNT_W-1:0] k;
  logic             done, load, s;
  logic [1:0]       p;
  logic [DIFF_W-1:0] ra, rb;
  logic [DEN_W-1:0] dden;
  logic [5:0][ENTRY_W-1:0] lane_entry;

  assign p    = row_r[2:1];
  assign s    = row_r[0];
  assign ra   = s ? head.c[p] : head.b[p];
  assign rb   = s ? head.b[p] : head.c[p];
  assign dden = {head.tmag, 1'b0};
  assign k    = cnt_r - CNT_ACC0;

  always_comb begin
    ctl.mul1      = head_valid && (cnt_r == CNT_MUL1);
    ctl.mul2      = head_valid && (cnt_r == CNT_MUL2);
    ctl.acc_en    = head_valid && (cnt_r >= CNT_ACC0) && (cnt_r <= CNT_ACC_LAST);
    ctl.acc_first = (cnt_r == CNT_ACC0);
    ctl.acc_term  = k[2];
    ctl.acc_part  = k[1:0];
    ctl.sgn       = head_valid && (cnt_r == CNT_SIGN);
    ctl.div       = head_valid && (cnt_r >= CNT_DIV0) && (cnt_r < CNT_DONE);
  end

  for (genvar j = 0; j < 6; j++) begin : g_lane
    localparam int Q = j / 2;
    localparam logic T = 1'(j % 2);
    logic [DIFF_W-1:0] ca, cb;
    assign ca = T ? head.c[Q] : head.b[Q];
    assign cb = T ? head.b[Q] : head.c[Q];
    tes_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .ra    (ra),
      .ca    (ca),
      .rb    (rb),
      .cb    (cb),
      .efa   ((s == T) ? ef00 : ef01),
      .efb   (ef22),
      .dden  (dden),
      .tneg  (head.tneg),
      .entry (lane_entry[j])
    );
  end

  assign done = head_valid && (cnt_r == CNT_DONE);
  assign load = done && (!out_valid_r || out_ready);
  assign pop  = load && (row_r == ROW_LAST);

  always_comb begin
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (head_valid && cnt_r != CNT_DONE) cnt_nxt = cnt_r + 6'd1;
    if (load) begin
      cnt_nxt       = CNT_MUL1;
      row_nxt       = (row_r == ROW_LAST) ? 3'd0 : row_r + 3'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CNT_MUL1;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r.local_row  <= row_r;
      res_r.global_row <= GROW_W'({head.node[p], s});
      res_r.entry      <= head.degen ? '0 : lane_entry;
      res_r.area       <= head.area;
      res_r.degen      <= head.degen;
      res_r.last       <= (row_r == ROW_LAST);
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

### hdl/triangle_element_stiffness_top.sv
// Constant-strain triangle element stiffness. Each input item is one triangle
// (three Q16.16 corners and three node numbers); the block returns six result
// items, rows 0..5 of the 6x6 stiffness A*B'CB in Q32.16, each with its global
// row (2*node + component), the signed area and a degenerate flag (zero area
// gives zero rows). The front pipeline takes an item per cycle, unless stalled
// by a full queue or by the material factor unit, into a two-entry queue; the
// back end forms each row in six column lanes with the 50-step restoring divide
// by 2|T| in each lane. After reset and after each configuration write the
// material factors are recomputed by a bit-serial divider; in_tready stays low
// during that time.
// Depends on tes_pkg, tes_mat, tes_front, tes_fifo, tes_lane, tes_back.
module triangle_element_stiffness_top import tes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item: in_tdata from bit 0: corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y (32 each), node_one, node_two, node_three (16 each)
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  // Result item: out_tdata from bit 0: local_row (3), global_row (17),
  // entry_a..entry_f (48 each), signed_area (48), zero pad (4)
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tuser,   // degenerate
  output logic                  out_tlast,   // last_row
  // Configuration: 0 young_modulus, 1 poisson_ratio, 2 plane_mode
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic            mat_ready;
  logic [EF_W-1:0] ef00, ef01, ef22;
  logic            q_full, q_push, q_valid, q_pop;
  elem_t           q_wr, q_head;
  result_t         res;

  tes_mat u_mat (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ready     (mat_ready),
    .ef00      (ef00),
    .ef01      (ef01),
    .ef22      (ef22)
  );

  tes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tready (in_tready),
    .mat_ready (mat_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr)
  );

  tes_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head)
  );

  tes_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .ef00       (ef00),
    .ef01       (ef01),
    .ef22       (ef22),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .res        (res)
  );

  assign out_tdata = {4'b0, res.area, res.entry, res.global_row, res.local_row};
  assign out_tuser = res.degen;
  assign out_tlast = res.last;

  `include "triangle_element_stiffness_top_assert.svh"

  // The last flag marks exactly the sixth row.
  `TES_ASSERT_IMP(a_last_row, out_tvalid, out_tlast == (res.local_row == ROW_LAST), "last flag and row disagree")
  // A degenerate element carries zero area and zero entries.
  `TES_ASSERT_IMP(a_degen_zero, out_tvalid && out_tuser, res.area == '0 && res.entry == '0, "degenerate row not zero")
  // Rows of one element follow in order.
  `TES_ASSERT_NXT(a_row_order, out_tvalid && out_tready && !out_tlast, !out_tvalid || res.local_row == $past(res.local_row) + 3'd1, "row sequence broken")

endmodule
